FILE: rtl/dsx_pkg.sv
package dsx_pkg;

	typedef enum logic [1:0] {
		FN_PUSH = 2'd0,
		FN_POP  = 2'd1,
		FN_XFER = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_DST_FULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FILL_EMPTY = 2'd0,
		FILL_PART  = 2'd1,
		FILL_FULL  = 2'd2
	} fill_t;

	localparam int WORD_W = 32;
	localparam int COUNT_OUT_W = 4;

endpackage

FILE: rtl/dsx_ram.sv
module dsx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/dual_stack_with_transfer_top.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   func, side, value
// out      output     out_valid / out_ready status, left/right count, fill, top
//
// Push, a refused operation or an unused code: result registered on accept, valid in the next cycle.
// Pop and transfer: the result waits in S_FETCH for the registered read of the next-lower entry
// from the source stack RAM, which becomes the new cached top.
// Reset clears both counts and the output valid; the RAMs are not cleared.
// A new item is taken once the previous one is finished and the output register
// is empty or drained in the same cycle.
module dual_stack_with_transfer_top
	import dsx_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               func,
	input  logic                     side,
	input  logic signed [WORD_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic [COUNT_OUT_W-1:0]   left_count,
	output logic [COUNT_OUT_W-1:0]   right_count,
	output logic [1:0]               left_fill,
	output logic [1:0]               right_fill,
	output logic signed [WORD_W-1:0] left_top,
	output logic signed [WORD_W-1:0] right_top
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic {
		S_IDLE,
		S_FETCH
	} state_t;

	state_t state_q;

	logic [CW-1:0]            cnt_q [2];
	logic [CW-1:0]            cnt_d [2];
	logic signed [WORD_W-1:0] top_q [2];
	logic signed [WORD_W-1:0] top_d [2];
	logic                     src_q;

	logic              ram_we    [2];
	logic [AW-1:0]     ram_waddr [2];
	logic [WORD_W-1:0] ram_wdata [2];
	logic              ram_re    [2];
	logic [AW-1:0]     ram_raddr [2];
	logic [WORD_W-1:0] ram_rdata [2];

	logic          in_fire;
	logic          src;
	logic          dst;
	logic [CW-1:0] scnt;
	logic [CW-1:0] dcnt;
	logic [CW-1:0] scnt_m2;
	logic          fetch;
	status_t       stat_d;
	logic signed [WORD_W-1:0] fetch_top [2];

	logic                     out_valid_q;
	status_t                  status_q;
	logic [COUNT_OUT_W-1:0]   cnt_out_q [2];
	fill_t                    fill_q [2];
	logic signed [WORD_W-1:0] top_out_q [2];

	function automatic logic [COUNT_OUT_W-1:0] cnt_low(logic [CW-1:0] c);
		logic [CW+COUNT_OUT_W-1:0] e;
		e = {{COUNT_OUT_W{1'b0}}, c};
		return e[COUNT_OUT_W-1:0];
	endfunction

	function automatic fill_t fill_of(logic [CW-1:0] c);
		fill_t f;
		if (c == '0) begin
			f = FILL_EMPTY;
		end else if (c == CW'(DEPTH)) begin
			f = FILL_FULL;
		end else begin
			f = FILL_PART;
		end
		return f;
	endfunction

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_fire  = in_valid && in_ready;

	assign src     = side;
	assign dst     = ~side;
	assign scnt    = cnt_q[src];
	assign dcnt    = cnt_q[dst];
	assign scnt_m2 = scnt - CW'(2);

	always_comb begin
		stat_d = ST_DONE;
		fetch  = 1'b0;
		for (int i = 0; i < 2; i++) begin
			cnt_d[i]     = cnt_q[i];
			top_d[i]     = top_q[i];
			ram_we[i]    = 1'b0;
			ram_waddr[i] = cnt_q[i][AW-1:0];
			ram_wdata[i] = $unsigned(value);
			ram_re[i]    = 1'b0;
			ram_raddr[i] = scnt_m2[AW-1:0];
		end
		case (func)
			FN_PUSH: begin
				if (scnt == CW'(DEPTH)) begin
					stat_d = ST_FULL;
				end else begin
					ram_we[src] = in_fire;
					cnt_d[src]  = scnt + CW'(1);
					top_d[src]  = value;
				end
			end
			FN_POP: begin
				if (scnt == '0) begin
					stat_d = ST_EMPTY;
				end else begin
					cnt_d[src]  = scnt - CW'(1);
					ram_re[src] = in_fire;
					fetch       = 1'b1;
				end
			end
			FN_XFER: begin
				if (scnt == '0) begin
					stat_d = ST_EMPTY;
				end else if (dcnt == CW'(DEPTH)) begin
					stat_d = ST_DST_FULL;
				end else begin
					ram_we[dst]    = in_fire;
					ram_wdata[dst] = $unsigned(top_q[src]);
					cnt_d[dst]     = dcnt + CW'(1);
					top_d[dst]     = top_q[src];
					cnt_d[src]     = scnt - CW'(1);
					ram_re[src]    = in_fire;
					fetch          = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			fetch_top[i] = top_q[i];
		end
		fetch_top[src_q] = $signed(ram_rdata[src_q]);
	end

	for (genvar g = 0; g < 2; g++) begin : g_stack
		dsx_ram #(
			.WIDTH(WORD_W),
			.DEPTH(DEPTH),
			.ADDR_W(AW)
		) u_ram (
			.clk  (clk),
			.we   (ram_we[g]),
			.waddr(ram_waddr[g]),
			.wdata(ram_wdata[g]),
			.re   (ram_re[g]),
			.raddr(ram_raddr[g]),
			.rdata(ram_rdata[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cnt_q[0]    <= '0;
			cnt_q[1]    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire && !fetch) begin
						out_valid_q <= 1'b1;
					end else if (out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (in_fire) begin
						src_q <= src;
						for (int i = 0; i < 2; i++) begin
							cnt_q[i] <= cnt_d[i];
							top_q[i] <= top_d[i];
						end
						if (fetch) begin
							state_q <= S_FETCH;
						end else begin
							status_q    <= stat_d;
							for (int i = 0; i < 2; i++) begin
								cnt_out_q[i] <= cnt_low(cnt_d[i]);
								fill_q[i]    <= fill_of(cnt_d[i]);
								top_out_q[i] <= (cnt_d[i] == '0) ? '0 : top_d[i];
							end
						end
					end
				end
				S_FETCH: begin
					// take the new top from the source RAM
					state_q     <= S_IDLE;
					out_valid_q <= 1'b1;
					status_q    <= ST_DONE;
					for (int i = 0; i < 2; i++) begin
						top_q[i]     <= fetch_top[i];
						cnt_out_q[i] <= cnt_low(cnt_q[i]);
						fill_q[i]    <= fill_of(cnt_q[i]);
						top_out_q[i] <= (cnt_q[i] == '0) ? '0 : fetch_top[i];
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign left_count  = cnt_out_q[0];
	assign right_count = cnt_out_q[1];
	assign left_fill   = fill_q[0];
	assign right_fill  = fill_q[1];
	assign left_top    = top_out_q[0];
	assign right_top   = top_out_q[1];

endmodule

FILE: rtl/dsx_checker.sv
module dsx_checker
	import dsx_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [1:0]               status,
	input logic [COUNT_OUT_W-1:0]   left_count,
	input logic [COUNT_OUT_W-1:0]   right_count,
	input logic [1:0]               left_fill,
	input logic [1:0]               right_fill,
	input logic signed [WORD_W-1:0] left_top,
	input logic signed [WORD_W-1:0] right_top
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(left_top) && $stable(right_top))
		else $error("result changed while stalled");

	a_left_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && left_fill == FILL_EMPTY |-> left_count == '0 && left_top == '0)
		else $error("left stack empty but count or top nonzero");

	a_right_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && right_fill == FILL_EMPTY |-> right_count == '0 && right_top == '0)
		else $error("right stack empty but count or top nonzero");

	a_refused_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL || status == ST_DST_FULL)
			|-> left_fill == FILL_FULL || right_fill == FILL_FULL)
		else $error("full status with no full stack");

endmodule

bind dual_stack_with_transfer_top dsx_checker #(.DEPTH(DEPTH)) u_dsx_checker (.*);

FILE: tb/dual_stack_with_transfer_top_tb.sv
module dual_stack_with_transfer_top_tb
	import dsx_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_DEPTH = 8;
	localparam int RANDOM_ITEMS = 580;
	localparam int SEGMENT_LEN = 30;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PRESSURE_AT = 200;
	localparam int PRESSURE_CYCLES = 120;
	localparam int REPORT_CAP = 200;
	localparam logic [1:0] FN_UNUSED = 2'd3;
	localparam logic SIDE_LEFT = 1'b0;
	localparam logic SIDE_RIGHT = 1'b1;

	typedef struct packed {
		status_t                  status;
		logic [COUNT_OUT_W-1:0]   left_count;
		logic [COUNT_OUT_W-1:0]   right_count;
		fill_t                    left_fill;
		fill_t                    right_fill;
		logic signed [WORD_W-1:0] left_top;
		logic signed [WORD_W-1:0] right_top;
	} stack_snapshot_t;

	class stack_pair_tracker;
		logic signed [WORD_W-1:0] words [2][STACK_DEPTH];
		int unsigned depth_used [2];
		stack_snapshot_t pending [$];
		int mismatches;
		int items_seen;
		int results_seen;
		int status_hits [4];

		function new();
			depth_used[0] = 0;
			depth_used[1] = 0;
			mismatches = 0;
			items_seen = 0;
			results_seen = 0;
			foreach (status_hits[i]) status_hits[i] = 0;
		endfunction

		function fill_t fill_of(int unsigned n);
			if (n == 0) return FILL_EMPTY;
			if (n >= STACK_DEPTH) return FILL_FULL;
			return FILL_PART;
		endfunction

		function logic signed [WORD_W-1:0] top_of(int s);
			if (depth_used[s] == 0) return '0;
			return words[s][depth_used[s]-1];
		endfunction

		function void note_item(logic [1:0] f, logic s, logic signed [WORD_W-1:0] v);
			stack_snapshot_t snap;
			int src;
			int dst;
			src = int'(s);
			dst = int'(!s);
			snap.status = ST_DONE;
			case (f)
				FN_PUSH: begin
					if (depth_used[src] >= STACK_DEPTH) begin
						snap.status = ST_FULL;
					end else begin
						words[src][depth_used[src]] = v;
						depth_used[src]++;
					end
				end
				FN_POP: begin
					if (depth_used[src] == 0) snap.status = ST_EMPTY;
					else depth_used[src]--;
				end
				FN_XFER: begin
					if (depth_used[src] == 0) begin
						snap.status = ST_EMPTY;
					end else if (depth_used[dst] >= STACK_DEPTH) begin
						snap.status = ST_DST_FULL;
					end else begin
						words[dst][depth_used[dst]] = top_of(src);
						depth_used[dst]++;
						depth_used[src]--;
					end
				end
				default: ;
			endcase
			snap.left_count = COUNT_OUT_W'(depth_used[0]);
			snap.right_count = COUNT_OUT_W'(depth_used[1]);
			snap.left_fill = fill_of(depth_used[0]);
			snap.right_fill = fill_of(depth_used[1]);
			snap.left_top = top_of(0);
			snap.right_top = top_of(1);
			pending.push_back(snap);
			items_seen++;
		endfunction

		function void flag(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
			mismatches++;
			if (mismatches <= REPORT_CAP)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
			if (mismatches == REPORT_CAP)
				$display("%0t: further mismatch reports suppressed", $time);
		endfunction

		function void check_result(stack_snapshot_t got);
			stack_snapshot_t want;
			results_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing pending, expected none, got status %0h",
					$time, got.status);
				return;
			end
			want = pending.pop_front();
			status_hits[want.status]++;
			if (got.status !== want.status)
				flag("status", WORD_W'(want.status), WORD_W'(got.status));
			if (got.left_count !== want.left_count)
				flag("left_count", WORD_W'(want.left_count), WORD_W'(got.left_count));
			if (got.right_count !== want.right_count)
				flag("right_count", WORD_W'(want.right_count), WORD_W'(got.right_count));
			if (got.left_fill !== want.left_fill)
				flag("left_fill", WORD_W'(want.left_fill), WORD_W'(got.left_fill));
			if (got.right_fill !== want.right_fill)
				flag("right_fill", WORD_W'(want.right_fill), WORD_W'(got.right_fill));
			if (got.left_top !== want.left_top) flag("left_top", want.left_top, got.left_top);
			if (got.right_top !== want.right_top)
				flag("right_top", want.right_top, got.right_top);
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [1:0]               func;
	logic                     side;
	logic signed [WORD_W-1:0] value;
	logic                     out_valid;
	logic                     out_ready;
	logic [1:0]               status;
	logic [COUNT_OUT_W-1:0]   left_count;
	logic [COUNT_OUT_W-1:0]   right_count;
	logic [1:0]               left_fill;
	logic [1:0]               right_fill;
	logic signed [WORD_W-1:0] left_top;
	logic signed [WORD_W-1:0] right_top;

	stack_pair_tracker tracker;
	bit sender_eager;
	int idle_cycles;

	dual_stack_with_transfer_top #(
		.DEPTH(STACK_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.side(side),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.left_count(left_count),
		.right_count(right_count),
		.left_fill(left_fill),
		.right_fill(right_fill),
		.left_top(left_top),
		.right_top(right_top)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		stack_snapshot_t got;
		if (arst_n) begin
			if (in_valid && in_ready) tracker.note_item(func, side, value);
			if (out_valid && out_ready) begin
				got.status = status_t'(status);
				got.left_count = left_count;
				got.right_count = right_count;
				got.left_fill = fill_t'(left_fill);
				got.right_fill = fill_t'(right_fill);
				got.left_top = left_top;
				got.right_top = right_top;
				tracker.check_result(got);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: timeout, no handshake for %0d cycles", $time, idle_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic send_item(logic [1:0] f, logic s, logic [WORD_W-1:0] v);
		int gap;
		gap = sender_eager ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		side <= s;
		value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '1;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_random(int count);
		int mode;
		int push_pct;
		int pop_pct;
		int xfer_pct;
		int r;
		logic lean_side;
		bit leaning;
		logic s;
		logic [1:0] f;
		mode = 0;
		push_pct = 0;
		pop_pct = 0;
		xfer_pct = 0;
		lean_side = SIDE_LEFT;
		leaning = 0;
		for (int n = 0; n < count; n++) begin
			if (n % SEGMENT_LEN == 0) begin
				mode = $urandom_range(0, 2);
				case (mode)
					0: begin push_pct = 60; pop_pct = 10; xfer_pct = 25; end
					1: begin push_pct = 15; pop_pct = 55; xfer_pct = 25; end
					default: begin push_pct = 35; pop_pct = 30; xfer_pct = 30; end
				endcase
				lean_side = 1'($urandom_range(0, 1));
				leaning = ($urandom_range(0, 1) == 0);
				sender_eager = ($urandom_range(0, 3) == 0);
			end
			r = $urandom_range(0, 99);
			if (r < push_pct) f = FN_PUSH;
			else if (r < push_pct + pop_pct) f = FN_POP;
			else if (r < push_pct + pop_pct + xfer_pct) f = FN_XFER;
			else f = FN_UNUSED;
			if (leaning && $urandom_range(0, 9) < 7) s = lean_side;
			else s = 1'($urandom_range(0, 1));
			send_item(f, s, pick_word());
		end
	endtask

	initial begin
		int gap;
		int taken;
		bit eager;
		taken = 0;
		eager = 0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (taken == PRESSURE_AT) begin
				out_ready <= 1'b0;
				repeat (PRESSURE_CYCLES) @(posedge clk);
			end else begin
				gap = eager ? 0 : $urandom_range(0, 4);
				if (gap != 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
			if (taken % 40 == 0) eager = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		tracker = new();
		idle_cycles = 0;
		sender_eager = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= FN_PUSH;
		side <= SIDE_LEFT;
		value <= '0;
		out_ready <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_item(FN_POP, SIDE_LEFT, '0);
		send_item(FN_POP, SIDE_RIGHT, '0);
		send_item(FN_XFER, SIDE_LEFT, '0);
		send_item(FN_XFER, SIDE_RIGHT, '0);
		send_item(FN_UNUSED, SIDE_LEFT, 32'h5A5A_A5A5);
		send_item(FN_PUSH, SIDE_LEFT, 32'h7FFF_FFFF);
		send_item(FN_PUSH, SIDE_LEFT, 32'h8000_0000);
		for (int i = 2; i < STACK_DEPTH; i++) send_item(FN_PUSH, SIDE_LEFT, 32'h1111_1111 * i);
		send_item(FN_PUSH, SIDE_LEFT, 32'hFFFF_FFFF);
		send_item(FN_PUSH, SIDE_RIGHT, 32'hFFFF_FFFF);
		send_item(FN_XFER, SIDE_RIGHT, '0);
		send_item(FN_XFER, SIDE_LEFT, '0);
		send_item(FN_POP, SIDE_RIGHT, '0);
		send_item(FN_UNUSED, SIDE_RIGHT, 32'hA5A5_5A5A);
		send_item(FN_POP, SIDE_RIGHT, '0);
		send_item(FN_POP, SIDE_LEFT, '0);

		run_random(RANDOM_ITEMS);
		in_valid <= 1'b0;

		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Ran %0d operations, %0d results checked, %0d mismatches.",
			tracker.items_seen, tracker.results_seen, tracker.mismatches);
		$display("Outcomes: %0d done, %0d push-full, %0d source-empty, %0d destination-full.",
			tracker.status_hits[ST_DONE], tracker.status_hits[ST_FULL],
			tracker.status_hits[ST_EMPTY], tracker.status_hits[ST_DST_FULL]);
		if (tracker.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
